// File: rtl/core/mesh_normal_tangent_accumulator_defines.svh
// Assertion macros shared by the checker.
`ifndef MESH_NORMAL_TANGENT_ACCUMULATOR_DEFINES_SVH
`define MESH_NORMAL_TANGENT_ACCUMULATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MNTA_ASSERT_IMP(name, clk, rstn, pre, post) \
	name: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
		else $error("mnta: implication failed");

// Next-cycle implication, disabled during reset.
`define MNTA_ASSERT_NXT(name, clk, rstn, pre, post) \
	name: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
		else $error("mnta: next-cycle check failed");

`endif

// File: rtl/core/mnta_pkg.sv
`timescale 1ns / 1ps

package mnta_pkg;

	// Default table depth.
	localparam int VERTEX_COUNT_DEF = 4096;

	// Command codes carried on tuser.
	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_TRI   = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	// One vertex table entry.
	typedef struct packed {
		logic signed [31:0] tan_z;
		logic signed [31:0] tan_y;
		logic signed [31:0] tan_x;
		logic signed [19:0] nrm_z;
		logic signed [19:0] nrm_y;
		logic signed [19:0] nrm_x;
		logic signed [15:0] tex_v;
		logic signed [15:0] tex_u;
		logic signed [31:0] pos_z;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_x;
	} vtx_entry_t;

endpackage

// File: rtl/core/mnta_vtx_mem.sv
`timescale 1ns / 1ps

module mnta_vtx_mem #(
	parameter int DEPTH = mnta_pkg::VERTEX_COUNT_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                clk,
	input  logic                we,
	input  logic [AW-1:0]       waddr,
	input  mnta_pkg::vtx_entry_t wdata,
	input  logic                re,
	input  logic [AW-1:0]       raddr,
	output mnta_pkg::vtx_entry_t rdata
);

	mnta_pkg::vtx_entry_t mem_q [DEPTH];
	mnta_pkg::vtx_entry_t rdata_q;

	// Write one entry, read one entry with registered data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/core/mnta_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module mnta_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [35:0] divisor,
	output logic        done,
	output logic [63:0] quot
);

	logic [35:0] rem_q;
	logic [63:0] quo_q;
	logic [35:0] dsr_q;
	logic [6:0]  cnt_q;
	logic        done_q;
	logic [36:0] rem_sh;
	logic [36:0] rem_sub;
	logic        fits;

	assign rem_sh  = {rem_q, quo_q[63]};
	assign rem_sub = rem_sh - {1'b0, dsr_q};
	assign fits    = (rem_sh >= {1'b0, dsr_q});

	// Count the steps and flag the last one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= 7'd64;
			end else if (cnt_q != 7'd0) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift in one dividend bit, subtract when the divisor fits.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (cnt_q != 7'd0) begin
			rem_q <= fits ? rem_sub[35:0] : rem_sh[35:0];
			quo_q <= {quo_q[62:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

// File: rtl/core/mesh_normal_tangent_accumulator.sv
`timescale 1ns / 1ps

// Channel   Dir  Fields (low bit up)
// s_axis    in   tuser: cmd; tdata: vertex_a, vertex_b, vertex_c, pos_x, pos_y, pos_z,
//                tex_u, tex_v
// m_axis    out  tdata: normal_x, normal_y, normal_z, tangent_x, tangent_y, tangent_z
//
// A write completes as it is accepted; a read goes through ST_OUT and waits there for the output register.
// A triangle's run is dominated by up to six passes of the 64-step shared divider,
// with the square root (32 steps) and the normalize shifts next.
// s_axis_tready is high only while idle; the output register holds a word until taken.
// Reset clears control only; the vertex table is undefined until each entry is written.
module mesh_normal_tangent_accumulator #(
	parameter int VERTEX_COUNT = mnta_pkg::VERTEX_COUNT_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// cmd
	input  logic [1:0]   s_axis_tuser,
	// vertex_a, vertex_b, vertex_c, pos_x, pos_y, pos_z, tex_u, tex_v, zero fill
	input  logic [167:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// normal_x, normal_y, normal_z, tangent_x, tangent_y, tangent_z, zero fill
	output logic [159:0] m_axis_tdata
);

	localparam int AW = $clog2(VERTEX_COUNT);
	localparam logic [4:0] TERM_A_LAST  = 5'd13;
	localparam logic [4:0] TERM_SQ_FIRST = 5'd14;
	localparam logic [4:0] TERM_SQ_LAST  = 5'd16;
	localparam logic [2:0] JOB_TAN_FIRST = 3'd3;
	localparam logic [2:0] JOB_END       = 3'd6;

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_RD   = 9'b000000010,
		ST_EDGE = 9'b000000100,
		ST_MUL  = 9'b000001000,
		ST_NORM = 9'b000010000,
		ST_SQRT = 9'b000100000,
		ST_DIV  = 9'b001000000,
		ST_WB   = 9'b010000000,
		ST_OUT  = 9'b100000000
	} state_t;

	function automatic logic in_range(input logic [11:0] idx);
		return 17'(idx) < 17'(VERTEX_COUNT);
	endfunction

	function automatic logic [AW-1:0] to_addr(input logic [11:0] idx);
		logic [16:0] t;
		t = 17'(idx);
		return t[AW-1:0];
	endfunction

	// True when v >>> k lies in [-2^30, 2^30).
	function automatic logic fits30(input logic signed [32:0] v, input logic [1:0] k);
		logic signed [32:0] s;
		s = v >>> k;
		return (s[32:30] == 3'b000) || (s[32:30] == 3'b111);
	endfunction

	function automatic logic [1:0] fit_k(input logic signed [32:0] x,
			input logic signed [32:0] y, input logic signed [32:0] z);
		logic [1:0] k;
		k = 2'd2;
		if (fits30(x, 2'd1) && fits30(y, 2'd1) && fits30(z, 2'd1)) begin
			k = 2'd1;
		end
		if (fits30(x, 2'd0) && fits30(y, 2'd0) && fits30(z, 2'd0)) begin
			k = 2'd0;
		end
		return k;
	endfunction

	function automatic logic signed [19:0] sat_n(input logic signed [19:0] a,
			input logic signed [15:0] b);
		logic signed [20:0] s;
		s = 21'(a) + 21'(b);
		if (s[20] != s[19]) begin
			return s[20] ? 20'sh80000 : 20'sh7FFFF;
		end
		return s[19:0];
	endfunction

	function automatic logic signed [31:0] sat_t(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [32:0] s;
		s = 33'(a) + 33'(b);
		if (s[32] != s[31]) begin
			return s[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
		end
		return s[31:0];
	endfunction

	state_t state_q;
	logic [1:0]  rc_q;
	logic        wph_q;
	logic [4:0]  term_q;
	logic        mph_q;
	logic [2:0]  job_q;
	logic        dwait_q;
	logic [4:0]  sq_cnt_q;
	logic        out_valid_q;
	logic        rd_zero_q;
	logic        nrm_ok_q;
	logic        tan_ok_q;

	logic [11:0] idx_q [3];
	logic signed [31:0] px_q [3];
	logic signed [31:0] py_q [3];
	logic signed [31:0] pz_q [3];
	logic signed [15:0] tu_q [3];
	logic signed [15:0] tv_q [3];
	logic signed [32:0] e0_q [3];
	logic signed [32:0] e1_q [3];
	logic signed [30:0] fa_q [3];
	logic signed [30:0] fb_q [3];
	logic signed [16:0] du1_q, dv1_q, du2_q, dv2_q;
	logic signed [67:0] prod_q;
	logic signed [63:0] acc_q;
	logic signed [63:0] c_q [3];
	logic signed [35:0] det_q;
	logic signed [51:0] num_q [3];
	logic [63:0] sumsq_q;
	logic [62:0] m_q [3];
	logic [63:0] sq_n_q, sq_r_q, sq_bit_q;
	logic signed [15:0] n_q [3];
	logic signed [31:0] t_q [3];
	logic [155:0] out_q;

	// Input fields.
	logic [11:0] in_a, in_b, in_c;
	logic        acc_in;
	assign in_a   = s_axis_tdata[11:0];
	assign in_b   = s_axis_tdata[23:12];
	assign in_c   = s_axis_tdata[35:24];
	assign acc_in = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);

	// Vertex table.
	logic                 mem_we, mem_re;
	logic [AW-1:0]        mem_waddr, mem_raddr;
	mnta_pkg::vtx_entry_t mem_wdata, mem_rdata, wr_ent, wb_ent;

	mnta_vtx_mem #(.DEPTH(VERTEX_COUNT), .AW(AW)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Entry for a vertex write: sums cleared.
	always_comb begin
		wr_ent       = '0;
		wr_ent.pos_x = s_axis_tdata[67:36];
		wr_ent.pos_y = s_axis_tdata[99:68];
		wr_ent.pos_z = s_axis_tdata[131:100];
		wr_ent.tex_u = s_axis_tdata[147:132];
		wr_ent.tex_v = s_axis_tdata[163:148];
	end

	// Entry for a corner update: add the triangle's contributions.
	always_comb begin
		wb_ent = mem_rdata;
		if (nrm_ok_q) begin
			wb_ent.nrm_x = sat_n(mem_rdata.nrm_x, n_q[0]);
			wb_ent.nrm_y = sat_n(mem_rdata.nrm_y, n_q[1]);
			wb_ent.nrm_z = sat_n(mem_rdata.nrm_z, n_q[2]);
		end
		if (tan_ok_q) begin
			wb_ent.tan_x = sat_t(mem_rdata.tan_x, t_q[0]);
			wb_ent.tan_y = sat_t(mem_rdata.tan_y, t_q[1]);
			wb_ent.tan_z = sat_t(mem_rdata.tan_z, t_q[2]);
		end
	end

	// Steer the table ports.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = to_addr(in_a);
		mem_wdata = wr_ent;
		mem_re    = 1'b0;
		mem_raddr = to_addr(idx_q[rc_q]);
		if (acc_in && s_axis_tuser == mnta_pkg::CMD_WRITE && in_range(in_a)) begin
			mem_we = 1'b1;
		end
		if (acc_in && s_axis_tuser == mnta_pkg::CMD_READ) begin
			mem_re    = 1'b1;
			mem_raddr = to_addr(in_a);
		end
		if (state_q == ST_RD && rc_q != 2'd3) begin
			mem_re = 1'b1;
		end
		if (state_q == ST_WB) begin
			mem_re    = !wph_q;
			mem_we    = wph_q;
			mem_waddr = to_addr(idx_q[rc_q]);
			mem_wdata = wb_ent;
		end
	end

	// Edge setup.
	logic signed [32:0] e0_n [3];
	logic signed [32:0] e1_n [3];
	logic [1:0] ka, kb;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			e0_n[i] = 33'(i == 0 ? px_q[1] : (i == 1 ? py_q[1] : pz_q[1]))
				- 33'(i == 0 ? px_q[0] : (i == 1 ? py_q[0] : pz_q[0]));
			e1_n[i] = 33'(i == 0 ? px_q[2] : (i == 1 ? py_q[2] : pz_q[2]))
				- 33'(i == 0 ? px_q[0] : (i == 1 ? py_q[0] : pz_q[0]));
		end
		ka = fit_k(e0_n[0], e0_n[1], e0_n[2]);
		kb = fit_k(e1_n[0], e1_n[1], e1_n[2]);
	end

	// Shared multiplier operands by term.
	logic signed [33:0] op_a, op_b;
	always_comb begin
		op_a = '0;
		op_b = '0;
		case (term_q)
			5'd0:  begin op_a = 34'(fa_q[1]); op_b = 34'(fb_q[2]); end
			5'd1:  begin op_a = 34'(fa_q[2]); op_b = 34'(fb_q[1]); end
			5'd2:  begin op_a = 34'(fa_q[2]); op_b = 34'(fb_q[0]); end
			5'd3:  begin op_a = 34'(fa_q[0]); op_b = 34'(fb_q[2]); end
			5'd4:  begin op_a = 34'(fa_q[0]); op_b = 34'(fb_q[1]); end
			5'd5:  begin op_a = 34'(fa_q[1]); op_b = 34'(fb_q[0]); end
			5'd6:  begin op_a = 34'(du1_q); op_b = 34'(dv2_q); end
			5'd7:  begin op_a = 34'(dv1_q); op_b = 34'(du2_q); end
			5'd8:  begin op_a = 34'(e0_q[0]); op_b = 34'(dv2_q); end
			5'd9:  begin op_a = 34'(e1_q[0]); op_b = 34'(dv1_q); end
			5'd10: begin op_a = 34'(e0_q[1]); op_b = 34'(dv2_q); end
			5'd11: begin op_a = 34'(e1_q[1]); op_b = 34'(dv1_q); end
			5'd12: begin op_a = 34'(e0_q[2]); op_b = 34'(dv2_q); end
			5'd13: begin op_a = 34'(e1_q[2]); op_b = 34'(dv1_q); end
			5'd14: begin
				op_a = signed'({4'b0, m_q[0][29:0]});
				op_b = signed'({4'b0, m_q[0][29:0]});
			end
			5'd15: begin
				op_a = signed'({4'b0, m_q[1][29:0]});
				op_b = signed'({4'b0, m_q[1][29:0]});
			end
			5'd16: begin
				op_a = signed'({4'b0, m_q[2][29:0]});
				op_b = signed'({4'b0, m_q[2][29:0]});
			end
			default: begin op_a = '0; op_b = '0; end
		endcase
	end

	// Accumulate step.
	logic t_first, t_last, t_neg;
	logic signed [63:0] term_v, acc_next;
	assign t_first  = (term_q <= TERM_A_LAST) ? !term_q[0] : (term_q == TERM_SQ_FIRST);
	assign t_last   = (term_q <= TERM_A_LAST) ? term_q[0] : (term_q == TERM_SQ_LAST);
	assign t_neg    = (term_q <= TERM_A_LAST) && term_q[0];
	assign term_v   = prod_q[63:0];
	assign acc_next = (t_first ? 64'sd0 : acc_q) + (t_neg ? -term_v : term_v);

	// Normalize checks.
	logic any_hi, all_lo;
	assign any_hi = (|m_q[0][62:30]) || (|m_q[1][62:30]) || (|m_q[2][62:30]);
	assign all_lo = !((|m_q[0][62:29]) || (|m_q[1][62:29]) || (|m_q[2][62:29]));

	// Square root step.
	logic [63:0] sq_trial;
	assign sq_trial = sq_r_q + sq_bit_q;

	// Divider jobs.
	logic [31:0] len;
	logic [35:0] md;
	logic [51:0] num_abs;
	logic [1:0]  jsel;
	logic [63:0] div_dend, div_q;
	logic [35:0] div_dsr;
	logic        div_start, div_done;
	logic        job_skip;
	assign len  = sq_r_q[31:0];
	assign md   = det_q[35] ? 36'(-det_q) : 36'(det_q);
	assign jsel = (job_q >= JOB_TAN_FIRST) ? 2'(job_q - JOB_TAN_FIRST) : job_q[1:0];
	assign num_abs = num_q[jsel][51] ? 52'(-num_q[jsel]) : 52'(num_q[jsel]);
	assign job_skip = (job_q == JOB_END) || (job_q == JOB_TAN_FIRST && !tan_ok_q);
	always_comb begin
		if (job_q < JOB_TAN_FIRST) begin
			div_dend = 64'({m_q[jsel][29:0], 14'b0}) + 64'(len[31:1]);
			div_dsr  = 36'(len);
		end else begin
			div_dend = {num_abs, 12'b0} + 64'(md[35:1]);
			div_dsr  = md;
		end
	end
	assign div_start = (state_q == ST_DIV) && !dwait_q && !job_skip;

	mnta_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dend),
		.divisor  (div_dsr),
		.done     (div_done),
		.quot     (div_q)
	);

	logic out_free;
	assign out_free = !out_valid_q || m_axis_tready;

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rc_q        <= '0;
			wph_q       <= 1'b0;
			term_q      <= '0;
			mph_q       <= 1'b0;
			job_q       <= '0;
			dwait_q     <= 1'b0;
			sq_cnt_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (acc_in) begin
						if (s_axis_tuser == mnta_pkg::CMD_READ) begin
							state_q <= ST_OUT;
						end else if (s_axis_tuser == mnta_pkg::CMD_TRI && in_range(in_a)
								&& in_range(in_b) && in_range(in_c)) begin
							state_q <= ST_RD;
							rc_q    <= '0;
						end
					end
				end
				ST_RD: begin
					rc_q <= rc_q + 2'd1;
					if (rc_q == 2'd3) begin
						state_q <= ST_EDGE;
					end
				end
				ST_EDGE: begin
					state_q <= ST_MUL;
					term_q  <= '0;
					mph_q   <= 1'b0;
				end
				ST_MUL: begin
					mph_q <= !mph_q;
					if (mph_q) begin
						term_q <= term_q + 5'd1;
						if (term_q == TERM_A_LAST) begin
							state_q <= ST_NORM;
						end else if (term_q == TERM_SQ_LAST) begin
							state_q  <= ST_SQRT;
							sq_cnt_q <= '0;
						end
					end
				end
				ST_NORM: begin
					if (!nrm_ok_q) begin
						state_q <= ST_DIV;
						job_q   <= JOB_TAN_FIRST;
						dwait_q <= 1'b0;
					end else if (!any_hi && !all_lo) begin
						state_q <= ST_MUL;
						mph_q   <= 1'b0;
					end
				end
				ST_SQRT: begin
					sq_cnt_q <= sq_cnt_q + 5'd1;
					if (sq_cnt_q == 5'd31) begin
						state_q <= ST_DIV;
						job_q   <= '0;
						dwait_q <= 1'b0;
					end
				end
				ST_DIV: begin
					if (!dwait_q) begin
						if (job_skip) begin
							if (nrm_ok_q || tan_ok_q) begin
								state_q <= ST_WB;
								rc_q    <= '0;
								wph_q   <= 1'b0;
							end else begin
								state_q <= ST_IDLE;
							end
						end else begin
							dwait_q <= 1'b1;
						end
					end else if (div_done) begin
						dwait_q <= 1'b0;
						job_q   <= job_q + 3'd1;
					end
				end
				ST_WB: begin
					wph_q <= !wph_q;
					if (wph_q) begin
						rc_q <= rc_q + 2'd1;
						if (rc_q == 2'd2) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (acc_in) begin
			idx_q[0]  <= in_a;
			idx_q[1]  <= in_b;
			idx_q[2]  <= in_c;
			rd_zero_q <= !in_range(in_a);
		end
		// Capture corner data in the cycle after its read.
		if (state_q == ST_RD && rc_q != 2'd0) begin
			px_q[rc_q - 2'd1] <= mem_rdata.pos_x;
			py_q[rc_q - 2'd1] <= mem_rdata.pos_y;
			pz_q[rc_q - 2'd1] <= mem_rdata.pos_z;
			tu_q[rc_q - 2'd1] <= mem_rdata.tex_u;
			tv_q[rc_q - 2'd1] <= mem_rdata.tex_v;
		end
		if (state_q == ST_EDGE) begin
			for (int i = 0; i < 3; i++) begin
				e0_q[i] <= e0_n[i];
				e1_q[i] <= e1_n[i];
				fa_q[i] <= 31'(e0_n[i] >>> ka);
				fb_q[i] <= 31'(e1_n[i] >>> kb);
			end
			du1_q <= 17'(tu_q[1]) - 17'(tu_q[0]);
			dv1_q <= 17'(tv_q[1]) - 17'(tv_q[0]);
			du2_q <= 17'(tu_q[2]) - 17'(tu_q[0]);
			dv2_q <= 17'(tv_q[2]) - 17'(tv_q[0]);
		end
		// Multiply, then accumulate and park the finished sum.
		if (state_q == ST_MUL) begin
			if (!mph_q) begin
				prod_q <= op_a * op_b;
			end else begin
				acc_q <= acc_next;
				if (t_last) begin
					case (term_q)
						5'd1:  c_q[0]   <= acc_next;
						5'd3:  c_q[1]   <= acc_next;
						5'd5:  c_q[2]   <= acc_next;
						5'd7:  det_q    <= acc_next[35:0];
						5'd9:  num_q[0] <= acc_next[51:0];
						5'd11: num_q[1] <= acc_next[51:0];
						5'd13: num_q[2] <= acc_next[51:0];
						default: sumsq_q <= acc_next;
					endcase
				end
				if (term_q == TERM_A_LAST) begin
					for (int i = 0; i < 3; i++) begin
						m_q[i] <= c_q[i][63] ? 63'(-c_q[i]) : 63'(c_q[i]);
					end
					nrm_ok_q <= (c_q[0] != 64'sd0) || (c_q[1] != 64'sd0) || (c_q[2] != 64'sd0);
					tan_ok_q <= (det_q != 36'sd0);
				end
			end
		end
		// Scale magnitudes one bit a cycle.
		if (state_q == ST_NORM && nrm_ok_q) begin
			for (int i = 0; i < 3; i++) begin
				if (any_hi) begin
					m_q[i] <= m_q[i] >> 1;
				end else if (all_lo) begin
					m_q[i] <= m_q[i] << 1;
				end
			end
		end
		// Integer square root, one result bit a cycle.
		if (state_q == ST_MUL && mph_q && term_q == TERM_SQ_LAST) begin
			sq_n_q   <= acc_next;
			sq_r_q   <= '0;
			sq_bit_q <= 64'h4000_0000_0000_0000;
		end else if (state_q == ST_SQRT) begin
			if (sq_n_q >= sq_trial) begin
				sq_n_q <= sq_n_q - sq_trial;
				sq_r_q <= (sq_r_q >> 1) + sq_bit_q;
			end else begin
				sq_r_q <= sq_r_q >> 1;
			end
			sq_bit_q <= sq_bit_q >> 2;
		end
		// Take the quotient and apply its sign; tangents are also clamped to limits.
		if (state_q == ST_DIV && dwait_q && div_done) begin
			if (job_q < JOB_TAN_FIRST) begin
				n_q[jsel] <= c_q[jsel][63] ? -signed'(div_q[15:0]) : signed'(div_q[15:0]);
			end else if (num_q[jsel][51] != det_q[35]) begin
				t_q[jsel] <= (div_q > 64'h8000_0000) ? 32'sh80000000
					: -signed'(div_q[31:0]);
			end else begin
				t_q[jsel] <= (div_q > 64'h7FFF_FFFF) ? 32'sh7FFFFFFF
					: signed'(div_q[31:0]);
			end
		end
		// Load the output word.
		if (state_q == ST_OUT && out_free) begin
			if (rd_zero_q) begin
				out_q <= '0;
			end else begin
				out_q <= {mem_rdata.tan_z, mem_rdata.tan_y, mem_rdata.tan_x,
					mem_rdata.nrm_z, mem_rdata.nrm_y, mem_rdata.nrm_x};
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0, out_q};

endmodule

// File: rtl/core/mnta_chk.sv
`timescale 1ns / 1ps
`include "mesh_normal_tangent_accumulator_defines.svh"

module mnta_chk (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic [1:0]   s_axis_tuser,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [159:0] m_axis_tdata
);

	// A read keeps the input side busy for its lookup.
	`MNTA_ASSERT_NXT(a_read_busy, clk, arst_n, s_axis_tvalid && s_axis_tready && s_axis_tuser == mnta_pkg::CMD_READ, !s_axis_tready)
	// A new output word follows a busy cycle.
	`MNTA_ASSERT_IMP(a_out_from_busy, clk, arst_n, $rose(m_axis_tvalid), !$past(s_axis_tready))
	// A read into an empty output register shows once it has passed through ST_OUT.
	`MNTA_ASSERT_IMP(a_read_lat, clk, arst_n, s_axis_tvalid && s_axis_tready && s_axis_tuser == mnta_pkg::CMD_READ && !m_axis_tvalid, ##2 m_axis_tvalid)
	// Hold a stalled word.
	`MNTA_ASSERT_NXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
	`MNTA_ASSERT_NXT(a_out_stable, clk, arst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))

endmodule

bind mesh_normal_tangent_accumulator mnta_chk u_mnta_chk (.*);
